// File: src/rcs_pkg.sv
`default_nettype none
package rcs_pkg;

  localparam int SCREEN_HEIGHT = 480;
  localparam int H_W           = 16;  // wall height bits, saturates at 2^16-1
  localparam int TEX_W         = 6;   // log2 of texture side
  localparam int TILE_W        = 6;   // log2 of tile side
  localparam int FRAC_SHIFT    = 22;  // Q.8 distance times Q1.14 trig
  localparam int P_W           = FRAC_SHIFT + TILE_W;
  localparam int NUM_W         = H_W + TEX_W;

  localparam logic [2:0] REG_CEIL   = 3'd0;
  localparam logic [2:0] REG_FLOOR  = 3'd1;
  localparam logic [2:0] REG_SCALE  = 3'd2;
  localparam logic [2:0] REG_PLAYX  = 3'd3;
  localparam logic [2:0] REG_PLAYY  = 3'd4;

  typedef enum logic [1:0] {
    KIND_CEIL  = 2'd0,
    KIND_FLOOR = 2'd1,
    KIND_WALL  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    FACE_N = 2'd0,
    FACE_S = 2'd1,
    FACE_W = 2'd2,
    FACE_E = 2'd3
  } face_e;

  typedef struct packed {
    logic [9:0]         column;
    logic [9:0]         pixel_row;
    logic [23:0]        distance;
    logic               is_horizontal;
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]  out_column;
    logic [9:0]  out_row;
    logic [1:0]  pixel_kind;
    logic [23:0] flat_color;
    logic [1:0]  texture_face;
    logic [5:0]  tex_x;
    logic [5:0]  tex_y;
  } out_beat_t;

  typedef struct packed {
    logic [9:0]     col;
    logic [9:0]     row;
    logic           horiz;
    face_e          face;
    logic [P_W-1:0] prod;
    logic           hzero;
    logic           hsat;
  } hside_t;

  typedef struct packed {
    logic [9:0]       col;
    logic [9:0]       row;
    kind_e            kind;
    face_e            face;
    logic [TEX_W-1:0] tx;
    logic             hzero;
    logic             ysat;
  } yside_t;

endpackage
`default_nettype wire

// File: src/rcs_hdiv.sv
`default_nettype none
module rcs_hdiv (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                valid_i,
  input  wire logic [32:0]         num_i,
  input  wire logic [23:0]         den_i,
  input  wire rcs_pkg::hside_t     side_i,
  output logic                     valid_o,
  output logic [rcs_pkg::H_W-1:0]  quo_o,
  output rcs_pkg::hside_t          side_o
);
  import rcs_pkg::*;

  // one restoring quotient bit per stage, MSB first
  logic           v_q [H_W];
  logic [32:0]    r_q [H_W];
  logic [23:0]    d_q [H_W];
  logic [H_W-1:0] q_q [H_W];
  hside_t         s_q [H_W];

  logic [32:0]    r_d [H_W];
  logic [H_W-1:0] q_d [H_W];

  always_comb begin
    logic [32:0]    r_in;
    logic [23:0]    d_in;
    logic [H_W-1:0] q_in;
    logic [39:0]    dsh;
    logic [39:0]    rr;
    for (int k = 0; k < H_W; k++) begin
      r_in = (k == 0) ? num_i : r_q[(k == 0) ? 0 : k - 1];
      d_in = (k == 0) ? den_i : d_q[(k == 0) ? 0 : k - 1];
      q_in = (k == 0) ? '0 : q_q[(k == 0) ? 0 : k - 1];
      dsh  = {16'b0, d_in} << (H_W - 1 - k);
      rr   = {7'b0, r_in};
      r_d[k] = r_in;
      q_d[k] = q_in;
      if (rr >= dsh) begin
        r_d[k] = 33'(rr - dsh);
        q_d[k] = q_in | (H_W'(1) << (H_W - 1 - k));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < H_W; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < H_W; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < H_W; k++) begin
        r_q[k] <= r_d[k];
        q_q[k] <= q_d[k];
      end
      d_q[0] <= den_i;
      s_q[0] <= side_i;
      for (int k = 1; k < H_W; k++) begin
        d_q[k] <= d_q[k-1];
        s_q[k] <= s_q[k-1];
      end
    end
  end

  assign valid_o = v_q[H_W-1];
  assign quo_o   = q_q[H_W-1];
  assign side_o  = s_q[H_W-1];

endmodule
`default_nettype wire

// File: src/rcs_ydiv.sv
`default_nettype none
module rcs_ydiv (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic [rcs_pkg::NUM_W-1:0] num_i,
  input  wire logic [rcs_pkg::H_W-1:0]   den_i,
  input  wire rcs_pkg::yside_t       side_i,
  output logic                       valid_o,
  output logic [rcs_pkg::TEX_W-1:0]  quo_o,
  output rcs_pkg::yside_t            side_o
);
  import rcs_pkg::*;

  logic             v_q [TEX_W];
  logic [NUM_W-1:0] r_q [TEX_W];
  logic [H_W-1:0]   d_q [TEX_W];
  logic [TEX_W-1:0] q_q [TEX_W];
  yside_t           s_q [TEX_W];

  logic [NUM_W-1:0] r_d [TEX_W];
  logic [TEX_W-1:0] q_d [TEX_W];

  always_comb begin
    logic [NUM_W-1:0] r_in;
    logic [H_W-1:0]   d_in;
    logic [TEX_W-1:0] q_in;
    logic [NUM_W:0]   dsh;
    for (int k = 0; k < TEX_W; k++) begin
      r_in = (k == 0) ? num_i : r_q[(k == 0) ? 0 : k - 1];
      d_in = (k == 0) ? den_i : d_q[(k == 0) ? 0 : k - 1];
      q_in = (k == 0) ? '0 : q_q[(k == 0) ? 0 : k - 1];
      dsh  = (NUM_W + 1)'(d_in) << (TEX_W - 1 - k);
      r_d[k] = r_in;
      q_d[k] = q_in;
      if ({1'b0, r_in} >= dsh) begin
        r_d[k] = NUM_W'({1'b0, r_in} - dsh);
        q_d[k] = q_in | (TEX_W'(1) << (TEX_W - 1 - k));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TEX_W; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
      for (int k = 1; k < TEX_W; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < TEX_W; k++) begin
        r_q[k] <= r_d[k];
        q_q[k] <= q_d[k];
      end
      d_q[0] <= den_i;
      s_q[0] <= side_i;
      for (int k = 1; k < TEX_W; k++) begin
        d_q[k] <= d_q[k-1];
        s_q[k] <= s_q[k-1];
      end
    end
  end

  assign valid_o = v_q[TEX_W-1];
  assign quo_o   = q_q[TEX_W-1];
  assign side_o  = s_q[TEX_W-1];

endmodule
`default_nettype wire

// File: src/raycast_column_pixel_shader.sv
// Raycast column pixel shader.
// Input channel: in_valid_i / in_stall_o carry one pixel beat (column, row,
// wall distance, hit orientation, ray cos/sin). Output channel: out_valid_o /
// out_stall_i carry one shaded beat per input beat, in order.
// A beat moves on a rising edge with valid high and stall low.
// Pipeline stages in order: input register, 16 stages of height division (one
// quotient bit each), a classify stage, 6 stages of texel-row division and
// the output register. Throughput is one beat per cycle unless stalled.
// The whole pipeline moves as one: it advances whenever the output register
// is empty or being taken. While the receiver stalls a full output register,
// in_stall_o is high and every stage holds its beat.
// Reset empties the pipeline and loads the register defaults (projection
// scale 9080935, all else zero). Registers are written through the APB
// port at byte address 4*index; write them only while the pipeline is empty.
`default_nettype none
module raycast_column_pixel_shader (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire rcs_pkg::in_beat_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rcs_pkg::out_beat_t     out_data_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import rcs_pkg::*;

  // ---------------- configuration registers ----------------
  logic [23:0] ceil_q, floor_q, px_q, py_q;
  logic [31:0] scale_q;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ceil_q  <= '0;
      floor_q <= '0;
      scale_q <= 32'd9080935;
      px_q    <= '0;
      py_q    <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_CEIL:  ceil_q  <= pwdata[23:0];
        REG_FLOOR: floor_q <= pwdata[23:0];
        REG_SCALE: scale_q <= pwdata;
        REG_PLAYX: px_q    <= pwdata[23:0];
        REG_PLAYY: py_q    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CEIL:  prdata = {8'b0, ceil_q};
      REG_FLOOR: prdata = {8'b0, floor_q};
      REG_SCALE: prdata = scale_q;
      REG_PLAYX: prdata = {8'b0, px_q};
      REG_PLAYY: prdata = {8'b0, py_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------- global pipeline enable ----------------
  logic en;
  out_beat_t out_q;
  logic      out_v_q;

  assign en         = !out_v_q || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------- stage 0: input register ----------------
  logic     in_v_q;
  in_beat_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_v_q <= 1'b0;
    else if (en) in_v_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) in_q <= in_data_i;
  end

  // ceil(scale/dist) = floor((scale + dist - 1) / dist); saturate up front
  // so the divider only needs 16 quotient bits.
  logic [32:0]        h_num;
  logic signed [15:0] trig;
  logic signed [40:0] prod_full;
  hside_t             hside;

  always_comb begin
    h_num     = {1'b0, scale_q} + {9'b0, in_q.distance} - 33'd1;
    trig      = in_q.is_horizontal ? in_q.cos_angle : in_q.sin_angle;
    prod_full = signed'({17'b0, in_q.distance}) * 41'(trig);
    hside.col   = in_q.column;
    hside.row   = in_q.pixel_row;
    hside.horiz = in_q.is_horizontal;
    if (in_q.is_horizontal)
      hside.face = (!in_q.sin_angle[15] && in_q.sin_angle != 16'sd0) ? FACE_N : FACE_S;
    else
      hside.face = (!in_q.cos_angle[15] && in_q.cos_angle != 16'sd0) ? FACE_W : FACE_E;
    hside.prod  = prod_full[P_W-1:0];
    hside.hzero = (in_q.distance == 24'd0);
    hside.hsat  = {7'b0, h_num} >= {in_q.distance, 16'b0};
  end

  // ---------------- wall height divider ----------------
  logic           hd_v;
  logic [H_W-1:0] hd_q;
  hside_t         hd_s;

  rcs_hdiv u_hdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_v_q),
    .num_i   (h_num),
    .den_i   (in_q.distance),
    .side_i  (hside),
    .valid_o (hd_v),
    .quo_o   (hd_q),
    .side_o  (hd_s)
  );

  // ---------------- classify stage ----------------
  logic [H_W-1:0]     h;
  logic signed [17:0] v, st, rs, diff;
  logic [P_W-1:0]     base, p;
  yside_t             yside_d;
  logic [NUM_W-1:0]   ynum_d;

  always_comb begin
    h    = hd_s.hzero ? '0 : (hd_s.hsat ? '1 : hd_q);
    v    = 18'(SCREEN_HEIGHT) - signed'({2'b0, h});
    st   = (v + signed'(18'(v[17]))) >>> 1;    // truncate toward zero
    rs   = signed'({8'b0, hd_s.row});
    diff = rs - st;
    base = hd_s.horiz ? {px_q[P_W-15:0], 14'b0} : {py_q[P_W-15:0], 14'b0};
    p    = hd_s.horiz ? base + hd_s.prod : base - hd_s.prod;

    yside_d.col   = hd_s.col;
    yside_d.row   = hd_s.row;
    yside_d.hzero = (h == '0);   // zero height: texel row stays 0
    yside_d.ysat  = (diff[H_W-1:0] == h);
    yside_d.face  = FACE_N;
    yside_d.tx    = '0;
    if (rs < st) begin
      yside_d.kind = KIND_CEIL;
    end else if (rs > st + signed'({2'b0, h})) begin
      yside_d.kind = KIND_FLOOR;
    end else begin
      yside_d.kind = KIND_WALL;
      yside_d.face = hd_s.face;
      yside_d.tx   = p[P_W-1:FRAC_SHIFT];
    end
    ynum_d = {diff[H_W-1:0], {TEX_W{1'b0}}};
  end

  logic             cl_v_q;
  yside_t           cl_s_q;
  logic [NUM_W-1:0] cl_num_q;
  logic [H_W-1:0]   cl_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cl_v_q <= 1'b0;
    else if (en) cl_v_q <= hd_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cl_s_q   <= yside_d;
      cl_num_q <= ynum_d;
      cl_h_q   <= h;
    end
  end

  // ---------------- texel row divider ----------------
  logic             yd_v;
  logic [TEX_W-1:0] yd_q;
  yside_t           yd_s;

  rcs_ydiv u_ydiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cl_v_q),
    .num_i   (cl_num_q),
    .den_i   (cl_h_q),
    .side_i  (cl_s_q),
    .valid_o (yd_v),
    .quo_o   (yd_q),
    .side_o  (yd_s)
  );

  // ---------------- output register ----------------
  out_beat_t out_d;

  always_comb begin
    out_d.out_column   = yd_s.col;
    out_d.out_row      = yd_s.row;
    out_d.pixel_kind   = yd_s.kind;
    out_d.texture_face = yd_s.face;
    out_d.tex_x        = yd_s.tx;
    out_d.tex_y        = '0;
    case (yd_s.kind)
      KIND_CEIL:  out_d.flat_color = ceil_q;
      KIND_FLOOR: out_d.flat_color = floor_q;
      default: begin
        out_d.flat_color = '0;
        if (!yd_s.hzero) out_d.tex_y = yd_s.ysat ? '1 : yd_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= yd_v;
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output backpressure");

  a_wall_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pixel_kind == KIND_WALL |-> out_data_o.flat_color == 24'd0)
    else $error("wall beat carries a flat color");

  a_flat_tex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.pixel_kind != KIND_WALL |->
      out_data_o.tex_x == 6'd0 && out_data_o.tex_y == 6'd0 &&
      out_data_o.texture_face == FACE_N)
    else $error("flat beat carries texel data");
`endif

endmodule
`default_nettype wire
